[rtl/slt_pkg.sv]
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants of the sorted list table
// Table depth, field widths, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

  // Table size and derived widths
  localparam int DEPTH  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DATA_W = 32;

  // Field widths
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Stream payload widths, padded to whole bytes
  localparam int IN_FIELDS_W  = MODE_W + DATA_W;
  localparam int OUT_FIELDS_W = STATUS_W + COUNT_W + DATA_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT     = 2'd0,
    MODE_REMOVE     = 2'd1,
    MODE_REMOVE_ODD = 2'd2,
    MODE_QUERY      = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_COMPACT,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

[rtl/sorted_list_table_top.sv]
// ----------------------------------------------------------------------------
// sorted_list_table_top: ascending table of signed 32-bit values
// Insert, remove, remove-odd and query over a RAM-held sorted table, walked
// one entry per cycle by a small sequencer.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata: mode[1:0], value[33:2]
//  m_*      out  m_tvalid/m_tready  tdata: status[1:0], count[6:2], smallest[38:7]
//
//  Query and refused operations go straight to the result; insert walks down
//  from the top to its position, remove and remove-odd walk all entries. The
//  pace is set by the single RAM read port, one entry walked per cycle.
//  Reset clears the entry count; table contents need no clearing.
//  A new transaction is taken while a result waits; the next result holds
//  until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_table_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output      logic                               s_tready,
  input  wire logic [slt_pkg::IN_TDATA_W-1:0]     s_tdata,   // mode, value
  output      logic                               m_tvalid,
  input  wire logic                               m_tready,
  output      logic [slt_pkg::OUT_TDATA_W-1:0]    m_tdata    // status, count, smallest
);

  localparam int CW = slt_pkg::CNT_W;
  localparam int AW = slt_pkg::ADDR_W;
  localparam int DW = slt_pkg::DATA_W;

  slt_pkg::state_t  state, state_next;
  slt_pkg::mode_t   mode, mode_next;
  slt_pkg::status_t stat, stat_next;
  logic signed [DW-1:0] value, value_next;
  logic [CW-1:0]    used, used_next;
  logic [CW-1:0]    idx, idx_next;
  logic [CW-1:0]    rptr, rptr_next;
  logic [CW-1:0]    wr, wr_next;
  logic             found, found_next;
  logic [DW-1:0]    min_val;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [DW-1:0]    ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [DW-1:0]    ram_rdata;

  logic             load_out;
  logic             accept;
  logic             drop;
  logic [CW-1:0]    wr_inc;
  slt_pkg::mode_t   in_mode;
  logic signed [DW-1:0] in_value;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == slt_pkg::S_IDLE);
  assign in_mode  = slt_pkg::mode_t'(s_tdata[1:0]);
  assign in_value = s_tdata[slt_pkg::IN_FIELDS_W-1:slt_pkg::MODE_W];

  // Entry storage
  slt_ram #(
    .WIDTH (DW),
    .DEPTH (slt_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Drop decision during compaction: first match, or any odd entry
  assign drop   = (mode == slt_pkg::MODE_REMOVE) ? (!found && ($signed(ram_rdata) == value))
                                                 : ram_rdata[0];
  assign wr_inc = wr + CW'(!drop);

  // Sequencer: next state, RAM control and result status
  always_comb begin
    state_next = state;
    mode_next  = mode;
    value_next = value;
    stat_next  = stat;
    used_next  = used;
    idx_next   = idx;
    rptr_next  = rptr;
    wr_next    = wr;
    found_next = found;
    ram_we     = 1'b0;
    ram_waddr  = AW'(idx);
    ram_wdata  = value;
    ram_raddr  = AW'(rptr);
    load_out   = 1'b0;

    case (state)
      slt_pkg::S_IDLE: begin
        ram_raddr = (in_mode == slt_pkg::MODE_INSERT) ? AW'(used - CW'(1)) : AW'(0);
        if (accept) begin
          mode_next  = in_mode;
          value_next = in_value;
          stat_next  = slt_pkg::STAT_OK;
          idx_next   = used;
          rptr_next  = CW'(1);
          wr_next    = '0;
          found_next = 1'b0;
          case (in_mode)
            slt_pkg::MODE_INSERT: begin
              if (used >= CW'(slt_pkg::DEPTH)) begin
                stat_next  = slt_pkg::STAT_FULL;
                state_next = slt_pkg::S_DONE;
              end else if (used == '0) begin
                state_next = slt_pkg::S_INS_PUT;
              end else begin
                state_next = slt_pkg::S_INS_CMP;
              end
            end
            slt_pkg::MODE_REMOVE, slt_pkg::MODE_REMOVE_ODD: begin
              if (used == '0) begin
                stat_next  = slt_pkg::STAT_EMPTY;
                state_next = slt_pkg::S_DONE;
              end else begin
                state_next = slt_pkg::S_COMPACT;
              end
            end
            default: begin
              state_next = slt_pkg::S_DONE;
            end
          endcase
        end
      end

      // Walk down from the top, shifting larger entries up by one
      slt_pkg::S_INS_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(idx);
        ram_raddr = AW'(idx - CW'(2));
        if ($signed(ram_rdata) > value) begin
          ram_wdata = ram_rdata;
          idx_next  = idx - CW'(1);
          if (idx == CW'(1)) begin
            state_next = slt_pkg::S_INS_PUT;
          end
        end else begin
          ram_wdata  = value;
          used_next  = used + CW'(1);
          state_next = slt_pkg::S_DONE;
        end
      end

      // Place the new value at the bottom slot
      slt_pkg::S_INS_PUT: begin
        ram_we     = 1'b1;
        ram_waddr  = AW'(idx);
        ram_wdata  = value;
        used_next  = used + CW'(1);
        state_next = slt_pkg::S_DONE;
      end

      // Stream entries down toward the bottom slot, keeping those not dropped
      slt_pkg::S_COMPACT: begin
        ram_raddr = AW'(rptr);
        rptr_next = rptr + CW'(1);
        ram_waddr = AW'(wr);
        ram_wdata = ram_rdata;
        if (drop) begin
          found_next = 1'b1;
        end else begin
          ram_we  = 1'b1;
          wr_next = wr_inc;
        end
        if (rptr == used) begin
          if (wr_inc == used) begin
            stat_next = slt_pkg::STAT_NOT_FOUND;
          end else begin
            used_next = wr_inc;
          end
          state_next = slt_pkg::S_DONE;
        end
      end

      // Hand the result to the output register once it is free
      slt_pkg::S_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = slt_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = slt_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= slt_pkg::S_IDLE;
      used     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    mode  <= mode_next;
    value <= value_next;
    stat  <= stat_next;
    idx   <= idx_next;
    rptr  <= rptr_next;
    wr    <= wr_next;
    found <= found_next;
    // Shadow of the bottom entry
    if (ram_we && (ram_waddr == AW'(0))) begin
      min_val <= ram_wdata;
    end
    if (load_out) begin
      m_tdata <= {(slt_pkg::OUT_TDATA_W - slt_pkg::OUT_FIELDS_W)'(0),
                  (used == '0) ? DW'(0) : min_val,
                  slt_pkg::COUNT_W'(used),
                  stat};
    end
  end

  // Checks
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CW'(slt_pkg::DEPTH))
    else $error("entry count beyond table depth");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == slt_pkg::S_DONE))
    else $error("result presented without finishing an operation");

  a_used_change: assert property (@(posedge clk) disable iff (rst)
    !$stable(used) |-> ($past(state == slt_pkg::S_INS_CMP) ||
                        $past(state == slt_pkg::S_INS_PUT) ||
                        $past(state == slt_pkg::S_COMPACT)))
    else $error("entry count changed outside an update");

  a_wr_behind: assert property (@(posedge clk) disable iff (rst)
    (state == slt_pkg::S_COMPACT) |-> (wr < rptr))
    else $error("compaction write pointer overtook read pointer");

  a_ins_idx: assert property (@(posedge clk) disable iff (rst)
    (state == slt_pkg::S_INS_CMP) |-> (idx != '0))
    else $error("insert walk below bottom slot");

endmodule

`default_nettype wire

[rtl/slt_ram.sv]
// ----------------------------------------------------------------------------
// slt_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[tb/sv/tb_sorted_list_table_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_list_table_top: self-checking bench for the sorted list table
// Drives mode/value transactions into the stream slave port and predicts
// every result from a queue-based copy of the ascending table. Each result
// on the master port is checked field by field against the oldest
// prediction. Directed cases cover the empty and full table, extreme and
// duplicate values and the remove-odd corner cases. A long random run then
// grows and shrinks the table with random gaps on both sides.
// ----------------------------------------------------------------------------

module tb_sorted_list_table_top;
  import slt_pkg::*;

  localparam int CLK_HALF   = 6;
  localparam int RAND_ITEMS = 1850;
  localparam int QUIET_TAIL = 150;
  localparam int DRAIN_CYC  = 3 * DEPTH + 10;

  typedef struct packed {
    status_t           status;
    logic [COUNT_W-1:0] count;
    logic signed [31:0] smallest;
  } table_result_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // mode[1:0], value[33:2]
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // status[1:0], count[6:2], smallest[38:7]

  // Predictor state and results waiting to be seen
  logic signed [31:0] held_values[$];
  table_result_t      pending_results[$];
  int                 errors;
  bit                 idle_en;

  sorted_list_table_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #CLK_HALF clk = ~clk;

  // Apply one operation to the predicted table and return its result
  function automatic table_result_t apply_table_op(mode_t op, logic signed [31:0] val);
    table_result_t      res;
    logic signed [31:0] kept[$];
    int                 pos;
    pos = 0;
    res.status = STAT_OK;
    case (op)
      MODE_INSERT: begin
        if (held_values.size() >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          while (pos < held_values.size() && held_values[pos] <= val) pos++;
          held_values.insert(pos, val);
        end
      end
      MODE_REMOVE: begin
        if (held_values.size() == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          while (pos < held_values.size() && held_values[pos] != val) pos++;
          if (pos >= held_values.size()) res.status = STAT_NOT_FOUND;
          else held_values.delete(pos);
        end
      end
      MODE_REMOVE_ODD: begin
        if (held_values.size() == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          foreach (held_values[i]) if (!held_values[i][0]) kept.push_back(held_values[i]);
          if (kept.size() == held_values.size()) res.status = STAT_NOT_FOUND;
          else held_values = kept;
        end
      end
      default: res.status = STAT_OK;
    endcase
    res.count    = COUNT_W'(held_values.size());
    res.smallest = (held_values.size() != 0) ? held_values[0] : 32'sd0;
    return res;
  endfunction

  // Send one transaction, with an optional gap in front of it
  task automatic send_op(input mode_t op, input logic signed [31:0] val);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[MODE_W-1:0]              = op;
    word[MODE_W +: DATA_W]        = val;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(apply_table_op(op, val));
  endtask

  // Hold the sender until every predicted result has been seen
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Mix of small, duplicate, extreme and full-range values
  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 12) - 6;
    if (r < 60 && held_values.size() != 0)
      return held_values[$urandom_range(0, held_values.size() - 1)];
    if (r < 70) begin
      case ($urandom_range(0, 4))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return -32'sd1;
        3: return 32'sd1;
        default: return 32'sd0;
      endcase
    end
    return $urandom;
  endfunction

  // Check each result transaction against the oldest prediction
  always @(posedge clk) begin
    table_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no prediction waiting: tdata %h", m_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[1:0] !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, m_tdata[1:0]);
          errors++;
        end
        if (m_tdata[6:2] !== want.count) begin
          $error("count mismatch: expected %0d, got %0d", want.count, m_tdata[6:2]);
          errors++;
        end
        if (m_tdata[38:7] !== want.smallest) begin
          $error("smallest mismatch: expected %0d, got %0d",
                 want.smallest, $signed(m_tdata[38:7]));
          errors++;
        end
      end
    end
  end

  // Stall the result side in random bursts
  initial begin : result_stall
    int n;
    forever begin
      @(posedge clk);
      if (!rst && idle_en && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 9);
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Operations on an empty table
  task automatic test_empty_table();
    send_op(MODE_QUERY, 32'sd0);
    send_op(MODE_REMOVE, 32'sd7);
    send_op(MODE_REMOVE_ODD, 32'sh7fff_ffff);
  endtask

  // Extremes, duplicates, absent values and odd negatives
  task automatic test_extremes_and_duplicates();
    send_op(MODE_INSERT, 32'sh7fff_ffff);
    send_op(MODE_INSERT, 32'sh8000_0000);
    send_op(MODE_INSERT, -32'sd1);
    send_op(MODE_INSERT, 32'sd0);
    send_op(MODE_INSERT, 32'sd0);
    send_op(MODE_REMOVE, 32'sd5);
    send_op(MODE_REMOVE, 32'sd0);
    send_op(MODE_REMOVE_ODD, 32'sd0);
    send_op(MODE_REMOVE_ODD, -32'sd1);
    send_op(MODE_QUERY, 32'sh5555_aaaa);
  endtask

  // Fill the table, refuse one more, then empty it completely
  task automatic test_fill_and_empty();
    while (held_values.size() < DEPTH) send_op(MODE_INSERT, pick_value());
    send_op(MODE_INSERT, 32'sd3);
    wait_drained();
    send_op(MODE_QUERY, 32'sd0);
    while (held_values.size() != 0)
      send_op(MODE_REMOVE, held_values[$urandom_range(0, held_values.size() - 1)]);
    send_op(MODE_QUERY, 32'sd0);
  endtask

  // Random operations that swing the table between empty and full
  task automatic test_random_ops();
    bit    growing;
    int    r;
    mode_t op;
    logic signed [31:0] val;
    growing = 1'b1;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      idle_en = ((i / 100) % 3 != 2) && (i < RAND_ITEMS - QUIET_TAIL);
      if (held_values.size() == DEPTH) growing = 1'b0;
      else if (held_values.size() == 0) growing = 1'b1;
      else if ($urandom_range(0, 79) == 0) growing = !growing;
      r = $urandom_range(0, 99);
      if (r < (growing ? 55 : 20)) op = MODE_INSERT;
      else if (r < (growing ? 75 : 80)) op = MODE_REMOVE;
      else if (r < (growing ? 80 : 85)) op = MODE_REMOVE_ODD;
      else op = MODE_QUERY;
      if (op == MODE_REMOVE && held_values.size() != 0 && $urandom_range(0, 9) < 8)
        val = held_values[$urandom_range(0, held_values.size() - 1)];
      else if (op == MODE_REMOVE_ODD || op == MODE_QUERY)
        val = $urandom;
      else
        val = pick_value();
      send_op(op, val);
      if (i % 300 == 299) wait_drained();
    end
  endtask

  // Run limit
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    clk      = 1'b0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    m_tready = 1'b0;
    errors   = 0;
    idle_en  = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_extremes_and_duplicates();
    test_fill_and_empty();
    test_random_ops();

    // Drain the remaining results, then watch for strays
    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d predicted results never arrived", pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/slt_pkg.sv
rtl/slt_ram.sv
rtl/sorted_list_table_top.sv
tb/sv/tb_sorted_list_table_top.sv
